/* rtl/core/pattern_occurrence_remover_assert.svh */
// Assertion macros for the pattern occurrence remover.
`ifndef PATTERN_OCCURRENCE_REMOVER_ASSERT_SVH
`define PATTERN_OCCURRENCE_REMOVER_ASSERT_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define POCR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pocr: same-cycle check failed");
// Antecedent implies consequent in the next cycle.
`define POCR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pocr: next-cycle check failed");
`else
`define POCR_ASSERT_NOW(label, ante, cons)
`define POCR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/core/pocr_pkg.sv */
// Shared constants, types and helper functions of the pattern occurrence remover.
`default_nettype none
package pocr_pkg;

	localparam int MAX_PATTERN = 32;
	localparam int FILL_W      = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W       = $clog2(MAX_PATTERN);
	localparam int CNT_W       = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int BYTES_PER_REG = CFG_DATA_W / 8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LEN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT0  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT8  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT16 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT24 = 3'd4;

	typedef logic [7:0] byte_t;
	typedef logic [MAX_PATTERN-1:0][7:0] win_t;
	typedef logic [FILL_W-1:0] fill_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Length in use: zero counts as one, anything above the window as the full window.
	function automatic fill_t eff_len(input fill_t raw);
		fill_t n;
		n = raw;
		if (raw == '0) n = fill_t'(1);
		if (raw > fill_t'(MAX_PATTERN)) n = fill_t'(MAX_PATTERN);
		return n;
	endfunction

	// True when the first n bytes of w equal those of p.
	function automatic logic window_match(input win_t w, input win_t p, input fill_t n);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if ((fill_t'(i) < n) && (w[i] != p[i])) ok = 1'b0;
		end
		return ok;
	endfunction

	// Drop the oldest byte; everything moves one place toward entry 0.
	function automatic win_t shift_down(input win_t w);
		win_t r;
		r = w;
		for (int i = 0; i < MAX_PATTERN - 1; i++) begin
			r[i] = w[i+1];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/pattern_occurrence_remover.sv */
// Top level of the pattern occurrence remover: window, matcher and result register.
//
// The block removes every leftmost, non-overlapping occurrence of a programmed
// byte pattern from a text stream. Items enter on the text channel (text_byte,
// final_byte) under text_valid/text_stall and leave on the result channel under
// result_valid/result_stall. Each result carries a kept byte, or, on the last
// result of a text, run_done with the number of removed occurrences.
// An accepted item sits in an input register, is compared against the pattern in
// parallel and, if it yields a byte, lands in the result register. In the steady
// state one item is taken per cycle while the result channel is not stalled. The
// single result register sets the extra cost: after the final item of a text,
// the bytes still held in the window leave one per cycle, again while the result
// is not stalled, followed by the closing result. After the pattern length is
// shortened mid-text, the surplus bytes are drained and the window is compared
// before the next item is consumed. The user must write the pattern through the
// cfg port (always ready) only while the block is idle; the block does not enforce it.
// Reset clears the window, the count and the result valid, sets the length to 1
// and the pattern to zero. A stalled result holds still; items that only grow the
// window or complete a match are still taken, and the first item that has to emit
// a byte waits in the input register and stalls the text channel in turn.
`default_nettype none
module pattern_occurrence_remover
	import pocr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Text channel
	input  wire logic                  text_valid,
	output logic                       text_stall,
	input  wire logic [7:0]            text_byte,
	input  wire logic                  final_byte,
	// Result channel
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output logic [7:0]                 kept_byte,
	output logic                       byte_present,
	output logic [15:0]                removed_count,
	output logic                       run_done,
	// Configuration write channel
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// Sequencer modes: normal streaming, draining surplus bytes after a
	// length change, and flushing the window at the end of a text.
	localparam logic [1:0] MODE_RUN    = 2'd0;
	localparam logic [1:0] MODE_SETTLE = 2'd1;
	localparam logic [1:0] MODE_FLUSH  = 2'd2;

	// Configuration registers.
	fill_t len_raw_q;
	win_t  pat_q;

	// Input register.
	logic  valid_s1;
	byte_t byte_s1;
	logic  final_s1;

	// Window state. The window bytes carry no reset; only bytes below
	// fill_q are ever looked at.
	win_t       win_q;
	fill_t      fill_q;
	cnt_t       cnt_q;
	logic [1:0] mode_q;
	logic       last_q;

	// Result register.
	logic  res_valid_q;
	byte_t res_byte_q;
	logic  res_present_q;
	cnt_t  res_count_q;
	logic  res_done_q;

	// Next-state and control.
	fill_t      len_eff;
	fill_t      fill_inc;
	win_t       cand;
	win_t       cmp_src;
	logic       hit;
	logic       out_free;
	logic       consume;
	logic       emit;
	logic       emit_final;
	byte_t      emit_byte;
	win_t       win_d;
	fill_t      fill_d;
	cnt_t       cnt_d;
	cnt_t       cnt_inc;
	logic [1:0] mode_d;
	logic       last_d;
	logic       in_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_raw_q <= fill_t'(1);
			pat_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LEN: begin
					len_raw_q <= cfg_data[FILL_W-1:0];
				end
				CFG_PAT0: begin
					for (int j = 0; j < BYTES_PER_REG; j++) pat_q[j] <= cfg_data[j*8 +: 8];
				end
				CFG_PAT8: begin
					for (int j = 0; j < BYTES_PER_REG; j++) begin
						pat_q[BYTES_PER_REG + j] <= cfg_data[j*8 +: 8];
					end
				end
				CFG_PAT16: begin
					for (int j = 0; j < BYTES_PER_REG; j++) begin
						pat_q[2*BYTES_PER_REG + j] <= cfg_data[j*8 +: 8];
					end
				end
				CFG_PAT24: begin
					for (int j = 0; j < BYTES_PER_REG; j++) begin
						pat_q[3*BYTES_PER_REG + j] <= cfg_data[j*8 +: 8];
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign len_eff  = eff_len(len_raw_q);
	assign fill_inc = fill_q + fill_t'(1);
	assign cnt_inc  = (cnt_q != '1) ? cnt_q + cnt_t'(1) : cnt_q;
	assign out_free = !res_valid_q || !result_stall;

	// The window as it looks with the new byte appended at the fill position.
	// In streaming mode the fill is always below the window size.
	always_comb begin
		cand = win_q;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (fill_q[IDX_W-1:0] == IDX_W'(i) && !fill_q[FILL_W-1]) cand[i] = byte_s1;
		end
	end

	// One comparator serves both the streaming step and the surplus drain.
	assign cmp_src = (mode_q == MODE_SETTLE) ? win_q : cand;
	assign hit     = window_match(cmp_src, pat_q, len_eff);

	always_comb begin
		win_d      = win_q;
		fill_d     = fill_q;
		cnt_d      = cnt_q;
		mode_d     = mode_q;
		last_d     = last_q;
		consume    = 1'b0;
		emit       = 1'b0;
		emit_final = 1'b0;
		emit_byte  = win_q[0];
		unique case (mode_q)
			MODE_RUN: begin
				emit_byte = cand[0];
				if (valid_s1) begin
					if (fill_inc > len_eff) begin
						// The length shrank under a partly filled window: take the
						// byte now and drain the surplus over the next cycles.
						consume = 1'b1;
						win_d   = cand;
						fill_d  = fill_inc;
						mode_d  = MODE_SETTLE;
						last_d  = final_s1;
					end else if (fill_inc == len_eff) begin
						if (hit) begin
							consume = 1'b1;
							fill_d  = '0;
							cnt_d   = cnt_inc;
							mode_d  = final_s1 ? MODE_FLUSH : MODE_RUN;
						end else if (out_free) begin
							consume = 1'b1;
							emit    = 1'b1;
							win_d   = shift_down(cand);
							fill_d  = len_eff - fill_t'(1);
							mode_d  = final_s1 ? MODE_FLUSH : MODE_RUN;
						end
					end else begin
						consume = 1'b1;
						win_d   = cand;
						fill_d  = fill_inc;
						mode_d  = final_s1 ? MODE_FLUSH : MODE_RUN;
					end
				end
			end
			MODE_SETTLE: begin
				if (out_free) begin
					if (fill_q > len_eff) begin
						emit   = 1'b1;
						win_d  = shift_down(win_q);
						fill_d = fill_q - fill_t'(1);
					end else begin
						if (hit) begin
							fill_d = '0;
							cnt_d  = cnt_inc;
						end else begin
							emit   = 1'b1;
							win_d  = shift_down(win_q);
							fill_d = fill_q - fill_t'(1);
						end
						mode_d = last_q ? MODE_FLUSH : MODE_RUN;
					end
				end
			end
			MODE_FLUSH: begin
				if (out_free) begin
					emit = 1'b1;
					if (fill_q != '0) begin
						win_d  = shift_down(win_q);
						fill_d = fill_q - fill_t'(1);
					end else begin
						// Closing result of the text; the count starts over.
						emit_final = 1'b1;
						cnt_d      = '0;
						mode_d     = MODE_RUN;
					end
				end
			end
			default: begin
				mode_d = MODE_RUN;
			end
		endcase
	end

	// The input register frees up in the same cycle its item is consumed.
	assign text_stall = valid_s1 && !consume;
	assign in_take    = text_valid && !text_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1  <= text_byte;
			final_s1 <= final_byte;
		end
	end

	always_ff @(posedge clk) begin
		win_q <= win_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			cnt_q  <= '0;
			mode_q <= MODE_RUN;
			last_q <= 1'b0;
		end else begin
			fill_q <= fill_d;
			cnt_q  <= cnt_d;
			mode_q <= mode_d;
			last_q <= last_d;
		end
	end

	// Result register. Every result reports the count as it stood before
	// this step's match, which is never the same step as an emitted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_byte_q    <= emit_final ? '0 : emit_byte;
			res_present_q <= !emit_final;
			res_count_q   <= cnt_q;
			res_done_q    <= emit_final;
		end
	end

	assign result_valid  = res_valid_q;
	assign kept_byte     = res_byte_q;
	assign byte_present  = res_present_q;
	assign removed_count = res_count_q;
	assign run_done      = res_done_q;

`include "pattern_occurrence_remover_assert.svh"

	// The closing result never carries a byte.
	`POCR_ASSERT_NOW(a_done_no_byte, result_valid && run_done, !byte_present && kept_byte == '0)
	// The surplus drain never runs below the pattern length.
	`POCR_ASSERT_NOW(a_settle_fill, mode_q == MODE_SETTLE, fill_q >= len_eff)
	// An empty flush produces the closing result and restarts the count.
	`POCR_ASSERT_NEXT(a_flush_close, mode_q == MODE_FLUSH && fill_q == '0 && out_free,
		result_valid && run_done && cnt_q == '0 && mode_q == MODE_RUN)

endmodule
`default_nettype wire
